// ===== rtl/core/chb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chb_pkg
// Shared types and constants for the chunked transfer body decoder.
// ---------------------------------------------------------------------------
package chb_pkg;

   // Default maximum number of hex digits on a size line.
   localparam int MaxSizeDigitsDefault = 8;
   localparam int DigitCntW            = 4;
   localparam int CountW               = 32;

   // Bytes skipped after each chunk's payload (normally CR LF).
   localparam logic [1:0] SuffixLen = 2'd2;
   localparam logic [7:0] LfByte    = 8'h0A;

   // Parser phase codes.
   localparam logic [2:0] PhDigits = 3'd0;
   localparam logic [2:0] PhFull   = 3'd1;
   localparam logic [2:0] PhRest   = 3'd2;
   localparam logic [2:0] PhData   = 3'd3;
   localparam logic [2:0] PhSuffix = 3'd4;
   localparam logic [2:0] PhHalt   = 3'd5;

   // Result kinds.
   localparam logic [1:0] KindPayload = 2'd0;
   localparam logic [1:0] KindEnd     = 2'd1;
   localparam logic [1:0] KindError   = 2'd2;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] kind;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           phase;
      logic [CountW-1:0]    remaining_count;
      logic [DigitCntW-1:0] digit_count;
      logic [1:0]           suffix_skip;
   } parse_state_type;

   localparam parse_state_type ParseStateReset = '{
      phase:           PhDigits,
      remaining_count: '0,
      digit_count:     '0,
      suffix_skip:     '0
   };

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      begin
         r = 5'd0;
         if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
         end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
         end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/chb_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chb_step
// Next-state and result logic of the chunked framing parser for one byte.
// ---------------------------------------------------------------------------
module chb_step
   import chb_pkg::*;
#(
   parameter int MAX_SIZE_DIGITS = MaxSizeDigitsDefault
) (
   input  wire req_type         item,
   input  wire parse_state_type cur_state,
   output parse_state_type      next_state,
   output logic                 emit,
   output rsp_type              result
);

   localparam logic [DigitCntW:0] MaxDigits = (DigitCntW + 1)'(MAX_SIZE_DIGITS);

   parse_state_type    st;
   logic [4:0]         hex;
   logic [DigitCntW:0] digits_inc;
   logic [CountW-1:0]  count_dec;
   logic [1:0]         skip_dec;

   always_comb begin
      // A restart puts the parser at the start of a new body first.
      st         = item.restart ? ParseStateReset : cur_state;
      hex        = hex_decode(item.body_byte);
      digits_inc = {1'b0, st.digit_count} + {{DigitCntW{1'b0}}, 1'b1};
      count_dec  = st.remaining_count - {{(CountW-1){1'b0}}, 1'b1};
      skip_dec   = st.suffix_skip - 2'd1;

      next_state = st;
      emit       = 1'b0;
      result     = '{payload_byte: 8'd0, kind: KindPayload};

      case (st.phase)
         PhDigits, PhFull: begin
            if (hex[4]) begin
               // One digit too many, or significant bits would be lost.
               if (st.phase == PhFull || st.remaining_count[CountW-1 -: 4] != 4'd0) begin
                  next_state.phase = PhHalt;
                  emit             = 1'b1;
                  result.kind      = KindError;
               end else begin
                  next_state.remaining_count = {st.remaining_count[CountW-5:0], hex[3:0]};
                  if (digits_inc >= MaxDigits) begin
                     next_state.phase = PhFull;
                  end else begin
                     next_state.digit_count = digits_inc[DigitCntW-1:0];
                  end
               end
            end else if (st.remaining_count == '0) begin
               // Empty or zero size line closes the body.
               next_state.phase = PhHalt;
               emit             = 1'b1;
               result.kind      = KindEnd;
            end else begin
               next_state.phase = (item.body_byte == LfByte) ? PhData : PhRest;
            end
         end
         PhRest: begin
            if (item.body_byte == LfByte) begin
               next_state.phase = PhData;
            end
         end
         PhData: begin
            next_state.remaining_count = count_dec;
            if (count_dec == '0) begin
               next_state.phase       = PhSuffix;
               next_state.suffix_skip = SuffixLen;
            end
            emit                = 1'b1;
            result.payload_byte = item.body_byte;
         end
         PhSuffix: begin
            next_state.suffix_skip = skip_dec;
            if (skip_dec == 2'd0) begin
               next_state.phase           = PhDigits;
               next_state.remaining_count = '0;
               next_state.digit_count     = '0;
            end
         end
         default: begin
            next_state.phase = PhHalt;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Strips HTTP/1.1 chunked transfer framing from a stream of body bytes.
//
//   Channel   Dir   Handshake             Payload
//   req       in    req_valid/req_stall   req_data   (body_byte, restart)
//   rsp       out   rsp_valid/rsp_stall   rsp_data   (payload_byte, kind)
//
// One byte is taken per cycle while req_stall is low; a request's result, if
// any, passes through the input register, then the result register.
// The parser state updates in the same cycle a request leaves the input
// register, so consecutive bytes follow each other without gaps.
// Synchronous active-high reset empties both registers and returns the
// parser to the start of a body.
// A stalled result blocks only requests that would produce a result; bytes
// that produce none keep flowing past it.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_core
   import chb_pkg::*;
#(
   parameter int MAX_SIZE_DIGITS = MaxSizeDigitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff;
   parse_state_type state_ff, state_in;

   parse_state_type step_state;
   logic            step_emit;
   rsp_type         step_result;
   logic            out_free;
   logic            advance;

   chb_step #(
      .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
   ) u_step (
      .item       (in_data_ff),
      .cur_state  (state_ff),
      .next_state (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   // Flow control between the input and result registers.
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && (out_free || !step_emit);
      req_stall    = in_valid_ff && !advance;
      in_valid_in  = req_valid || (in_valid_ff && !advance);
      out_valid_in = (advance && step_emit) || (out_valid_ff && rsp_stall);
      state_in     = advance ? step_state : state_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ParseStateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A stall on the request side only ever comes from a held item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && step_emit && out_valid_ff))
      else $error("request stalled without a blocked result");

   // The digit counter stays below the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, state_ff.digit_count} < (DigitCntW + 1)'(MAX_SIZE_DIGITS)))
      else $error("digit count reached limit");

   // Data phase always has bytes left to pass.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PhData) |-> (state_ff.remaining_count != '0))
      else $error("data phase with zero count");

   // Suffix phase always has bytes left to skip.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PhSuffix) |-> (state_ff.suffix_skip != 2'd0))
      else $error("suffix phase with nothing to skip");

   // A result accepted downstream is replaced only by a new emitting item.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && !(advance && step_emit)) |=> !out_valid_ff)
      else $error("result register did not drain");

endmodule
`default_nettype wire
